### rtl/tcpop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpop_pkg
// Shared types, codes and helpers of the TCP option area parser.
// ----------------------------------------------------------------------------
package tcpop_pkg;

   // Largest option area in bytes; longer declared areas are clipped to it.
   localparam int MAX_AREA_BYTES = 40;
   localparam int REM_W          = $clog2(MAX_AREA_BYTES + 1);

   // Depth of the record queue in front of the result port.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_STOPPED = 2'd0,
      PH_KIND    = 2'd1,
      PH_LEN     = 2'd2,
      PH_BODY    = 2'd3
   } phase_type;

   // Option kind bytes with a meaning of their own.
   localparam logic [7:0] K_EOL   = 8'd0;
   localparam logic [7:0] K_NOP   = 8'd1;
   localparam logic [7:0] K_MSS   = 8'd2;
   localparam logic [7:0] K_WS    = 8'd3;
   localparam logic [7:0] K_SACKP = 8'd4;
   localparam logic [7:0] K_TS    = 8'd8;

   // Record type codes.
   localparam logic [3:0] R_EOL    = 4'd0;
   localparam logic [3:0] R_NOP    = 4'd1;
   localparam logic [3:0] R_MSS    = 4'd2;
   localparam logic [3:0] R_WS     = 4'd3;
   localparam logic [3:0] R_SACKP  = 4'd4;
   localparam logic [3:0] R_TS     = 4'd5;
   localparam logic [3:0] R_OTHER  = 4'd6;
   localparam logic [3:0] R_BADOPT = 4'd7;
   localparam logic [3:0] R_BADLEN = 4'd8;
   localparam logic [3:0] R_TRUNC  = 4'd9;

   // Option lengths that the fixed-format options must carry.
   localparam logic [7:0] LEN_MSS = 8'd4;
   localparam logic [7:0] LEN_WS  = 8'd3;
   localparam logic [7:0] LEN_TS  = 8'd10;

   typedef struct packed {
      logic [7:0]  opt_kind;
      logic [3:0]  record_type;
      logic [31:0] value_a;
      logic [31:0] value_b;
      logic [7:0]  length_field;
      logic        last_record;
   } rec_type;

   function automatic rec_type make_rec(logic [7:0] kind, logic [3:0] rtype,
                                        logic [7:0] len, logic last);
      rec_type r;
      r.opt_kind     = kind;
      r.record_type  = rtype;
      r.value_a      = 32'd0;
      r.value_b      = 32'd0;
      r.length_field = len;
      r.last_record  = last;
      return r;
   endfunction

   // Record of a complete option, from its kind, length and gathered data.
   function automatic rec_type finish_option(logic [7:0] kind, logic [7:0] len,
                                             logic [63:0] data, logic last);
      rec_type r;
      r = make_rec(kind, R_OTHER, len, last);
      case (kind)
         K_MSS: begin
            if (len == LEN_MSS) begin
               r.record_type = R_MSS;
               r.value_a     = {16'd0, data[15:0]};
            end else begin
               r.record_type = R_BADOPT;
            end
         end
         K_WS: begin
            if (len == LEN_WS) begin
               r.record_type = R_WS;
               r.value_a     = {24'd0, data[7:0]};
            end else begin
               r.record_type = R_BADOPT;
            end
         end
         K_SACKP: begin
            r.record_type = R_SACKP;
         end
         K_TS: begin
            if (len == LEN_TS) begin
               r.record_type = R_TS;
               r.value_a     = data[63:32];
               r.value_b     = data[31:0];
            end else begin
               r.record_type = R_BADOPT;
            end
         end
         default: begin
            r.record_type = (len == 8'd1) ? R_BADOPT : R_OTHER;
         end
      endcase
      return r;
   endfunction

endpackage

### rtl/tcp_option_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_option_parser_top
// Splits a TCP option area, fed one byte per item, into option records.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one option byte per item. The first byte of
//   an area comes with req_area_start high and the area length on
//   req_area_len; lengths above 40 are clipped. A rising edge with req_valid
//   high and req_stall low accepts the item.
//   The response channel returns one item per option record, in wire order.
//   A record leaves with the last byte of its option; a length byte of one
//   gives two records. rsp_last_record marks the record that ends the area.
//   A record enters the queue at the edge that accepts the byte completing
//   it, and is presented once the records ahead of it have been taken.
//   Throughput: one byte per cycle while req_stall is low. Each byte only
//   updates the parser state registers, and records go into a four-entry
//   queue in front of the response port, so the request side keeps flowing
//   while a record waits for the receiver.
//   When the receiver stalls, the queue fills and req_stall rises once fewer
//   than two entries are free, so the worst case of two records per byte
//   always fits. A stalled response item holds its value.
//   Synchronous reset empties the queue and leaves the parser stopped,
//   waiting for the next area start; bytes without an area start are then
//   dropped.
// ----------------------------------------------------------------------------
module tcp_option_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_opt_byte,
   input  logic        req_area_start,
   input  logic [5:0]  req_area_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_opt_kind,
   output logic [3:0]  rsp_record_type,
   output logic [31:0] rsp_value_a,
   output logic [31:0] rsp_value_b,
   output logic [7:0]  rsp_length_field,
   output logic        rsp_last_record
);
   import tcpop_pkg::*;

   // Parser state.
   phase_type          phase_ff, phase_in;
   logic [7:0]         kind_ff, kind_in;
   logic [7:0]         decl_ff, decl_in;
   logic [7:0]         seen_ff, seen_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [63:0]        vs_ff, vs_in;

   // Record queue.
   rec_type            queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0] count_ff;

   logic               accept, pop;
   logic [7:0]         area_len_ext;
   logic [REM_W-1:0]   area_len_clip;

   // State as seen by this byte, after an area start has been applied.
   phase_type          cur_phase;
   logic [REM_W-1:0]   cur_rem, rem_dec;
   logic [7:0]         cur_decl, cur_seen, seen_inc;
   logic [63:0]        cur_vs, vs_shift;
   logic               active, len_bad, body_done, rem_last;

   logic               push0, push1;
   rec_type            rec0, rec1;

   assign accept = req_valid && !req_stall;
   assign pop    = rsp_valid && !rsp_stall;

   // Room for two records is always kept, since one byte can produce two.
   assign req_stall = (count_ff > QUEUE_CW'(QUEUE_DEPTH - 2));

   assign area_len_ext  = {2'd0, req_area_len};
   assign area_len_clip = (area_len_ext > 8'(MAX_AREA_BYTES)) ?
                          REM_W'(MAX_AREA_BYTES) : REM_W'(area_len_ext);

   always_comb begin
      if (req_area_start) begin
         cur_phase = (req_area_len == 6'd0) ? PH_STOPPED : PH_KIND;
         cur_rem   = area_len_clip;
         cur_decl  = 8'd0;
         cur_seen  = 8'd0;
         cur_vs    = 64'd0;
      end else begin
         cur_phase = phase_ff;
         cur_rem   = rem_ff;
         cur_decl  = decl_ff;
         cur_seen  = seen_ff;
         cur_vs    = vs_ff;
      end
   end

   assign active    = (cur_phase != PH_STOPPED) && (cur_rem != '0);
   assign rem_dec   = cur_rem - REM_W'(1);
   assign rem_last  = (rem_dec == '0);
   // The length may cover the kind byte, this byte and all bytes still left in the area.
   assign len_bad   = (req_opt_byte == 8'd0) ||
                      ({1'b0, req_opt_byte} > (9'(cur_rem) + 9'd1));
   assign seen_inc  = cur_seen + 8'd1;
   assign body_done = (seen_inc >= cur_decl);
   assign vs_shift  = {cur_vs[55:0], req_opt_byte};

   // Next parse phase.
   always_comb begin
      phase_in = PH_STOPPED;
      if (active) begin
         case (cur_phase)
            PH_KIND: begin
               if (req_opt_byte == K_EOL) begin
                  phase_in = PH_STOPPED;
               end else if (req_opt_byte == K_NOP) begin
                  phase_in = rem_last ? PH_STOPPED : PH_KIND;
               end else if (cur_rem == REM_W'(1)) begin
                  phase_in = PH_STOPPED;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (len_bad || rem_last) begin
                  phase_in = PH_STOPPED;
               end else if (req_opt_byte > 8'd2) begin
                  phase_in = PH_BODY;
               end else begin
                  phase_in = PH_KIND;
               end
            end
            PH_BODY: begin
               if (rem_last) begin
                  phase_in = PH_STOPPED;
               end else if (body_done) begin
                  phase_in = PH_KIND;
               end else begin
                  phase_in = PH_BODY;
               end
            end
            default: begin
               phase_in = PH_STOPPED;
            end
         endcase
      end
   end

   // Counters and the data gathered from the option body.
   always_comb begin
      rem_in  = active ? rem_dec : cur_rem;
      kind_in = (active && cur_phase == PH_KIND) ? req_opt_byte : kind_ff;
      decl_in = (active && cur_phase == PH_LEN) ? req_opt_byte : cur_decl;
      seen_in = cur_seen;
      vs_in   = cur_vs;
      if (active && cur_phase == PH_LEN) begin
         seen_in = 8'd2;
         vs_in   = 64'd0;
      end else if (active && cur_phase == PH_BODY) begin
         seen_in = seen_inc;
         vs_in   = vs_shift;
      end
   end

   // Records produced by this byte. The second one is only ever the no-op
   // that a length byte of one also stands for.
   always_comb begin
      push0 = 1'b0;
      push1 = 1'b0;
      rec0  = make_rec(req_opt_byte, R_EOL, 8'd0, 1'b1);
      rec1  = make_rec(K_NOP, R_NOP, 8'd0, rem_last);
      if (active) begin
         case (cur_phase)
            PH_KIND: begin
               if (req_opt_byte == K_EOL) begin
                  push0 = 1'b1;
               end else if (req_opt_byte == K_NOP) begin
                  push0 = 1'b1;
                  rec0  = make_rec(req_opt_byte, R_NOP, 8'd0, rem_last);
               end else if (cur_rem == REM_W'(1)) begin
                  push0 = 1'b1;
                  rec0  = make_rec(req_opt_byte, R_TRUNC, 8'd0, 1'b1);
               end
            end
            PH_LEN: begin
               if (len_bad) begin
                  push0 = 1'b1;
                  rec0  = make_rec(kind_ff, R_BADLEN, req_opt_byte, 1'b1);
               end else if (req_opt_byte == 8'd1) begin
                  push0 = 1'b1;
                  push1 = 1'b1;
                  rec0  = finish_option(kind_ff, 8'd1, 64'd0, 1'b0);
               end else if (req_opt_byte == 8'd2) begin
                  push0 = 1'b1;
                  rec0  = finish_option(kind_ff, 8'd2, 64'd0, rem_last);
               end
            end
            PH_BODY: begin
               if (body_done) begin
                  push0 = 1'b1;
                  rec0  = finish_option(kind_ff, cur_decl, vs_shift, rem_last);
               end
            end
            default: begin
               push0 = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STOPPED;
         kind_ff   <= 8'd0;
         decl_ff   <= 8'd0;
         seen_ff   <= 8'd0;
         rem_ff    <= '0;
         vs_ff     <= 64'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         decl_ff   <= decl_in;
         seen_ff   <= seen_in;
         rem_ff    <= rem_in;
         vs_ff     <= vs_in;
      end
   end

   // Queue storage: payload only, no reset needed.
   always_ff @(posedge clock) begin
      if (accept && push0) begin
         queue_ff[wr_ptr_ff] <= rec0;
      end
      if (accept && push1) begin
         queue_ff[wr_ptr_ff + QUEUE_AW'(1)] <= rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(accept && push0)
                                + QUEUE_AW'(accept && push1);
         rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(pop);
         count_ff  <= count_ff + QUEUE_CW'(accept && push0)
                               + QUEUE_CW'(accept && push1)
                               - QUEUE_CW'(pop);
      end
   end

   assign rsp_valid        = (count_ff != '0);
   assign rsp_opt_kind     = queue_ff[rd_ptr_ff].opt_kind;
   assign rsp_record_type  = queue_ff[rd_ptr_ff].record_type;
   assign rsp_value_a      = queue_ff[rd_ptr_ff].value_a;
   assign rsp_value_b      = queue_ff[rd_ptr_ff].value_b;
   assign rsp_length_field = queue_ff[rd_ptr_ff].length_field;
   assign rsp_last_record  = queue_ff[rd_ptr_ff].last_record;

endmodule
